// ===== hw/rtl/ipow_pkg.sv =====
package ipow_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam word_t WORD_ONE = word_t'(1);
    localparam cnt_t  CNT_TOP  = cnt_t'(WIDTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ALIGN  = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        word_t product;
    } mul_rsp_t;

endpackage

// ===== hw/rtl/integer_power_by_squaring.sv =====
// Exponent <= 0 goes straight from idle to the finish state and returns 1.
// Otherwise the align state skips the leading zeros of the exponent, then each bit below its
// top one costs a square in the multiplier, and each one among them a further multiply.
// Throughput: one item at a time; the bit-serial multiplier (one partial product per cycle) sets it.
// Reset: rst_n, asynchronous, active low, clears control state and the output beat.
module integer_power_by_squaring
    import ipow_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [WIDTH-1:0]  base,
    input  logic signed [WIDTH-1:0]  exponent,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WIDTH-1:0]  power
);

    state_t   state_reg, state_next;
    word_t    base_reg, base_next;
    word_t    exp_reg, exp_next;
    word_t    acc_reg, acc_next;
    cnt_t     cnt_reg, cnt_next;
    logic     start_reg, start_next;
    word_t    opa_reg, opa_next;
    word_t    opb_reg, opb_next;
    logic     out_valid_reg, out_valid_next;
    word_t    power_reg, power_next;
    mul_req_t mreq;
    mul_rsp_t mrsp;

    assign mreq.start = start_reg;
    assign mreq.a     = opa_reg;
    assign mreq.b     = opb_reg;

    ipow_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        start_next     = 1'b0;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        out_valid_next = out_valid_reg;
        power_next     = power_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next = word_t'(base);
                    exp_next  = word_t'(exponent);
                    cnt_next  = CNT_TOP;
                    if (exponent[WIDTH-1] || (exponent == '0))
                    begin
                        acc_next   = WORD_ONE;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                // skip leading zeros, then seed with the base at the top one
                if (exp_reg[WIDTH-1])
                begin
                    acc_next = base_reg;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        exp_next   = {exp_reg[WIDTH-2:0], 1'b0};
                        cnt_next   = cnt_reg - cnt_t'(1);
                        opa_next   = base_reg;
                        opb_next   = base_reg;
                        start_next = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
                else
                begin
                    exp_next = {exp_reg[WIDTH-2:0], 1'b0};
                    cnt_next = cnt_reg - cnt_t'(1);
                end
            end
            ST_SQUARE:
            begin
                if (mrsp.done)
                begin
                    acc_next = mrsp.product;
                    if (exp_reg[WIDTH-1])
                    begin
                        opa_next   = mrsp.product;
                        opb_next   = base_reg;
                        start_next = 1'b1;
                        state_next = ST_MULT;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        exp_next   = {exp_reg[WIDTH-2:0], 1'b0};
                        cnt_next   = cnt_reg - cnt_t'(1);
                        opa_next   = mrsp.product;
                        opb_next   = mrsp.product;
                        start_next = 1'b1;
                    end
                end
            end
            ST_MULT:
            begin
                if (mrsp.done)
                begin
                    acc_next = mrsp.product;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        exp_next   = {exp_reg[WIDTH-2:0], 1'b0};
                        cnt_next   = cnt_reg - cnt_t'(1);
                        opa_next   = mrsp.product;
                        opb_next   = mrsp.product;
                        start_next = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    power_next     = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        exp_reg   <= exp_next;
        acc_reg   <= acc_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        power_reg <= power_next;
    end

    assign out_valid = out_valid_reg;
    assign power     = power_reg;

endmodule

// ===== hw/rtl/ipow_mul.sv =====
module ipow_mul
    import ipow_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    word_t a_reg, a_next;
    word_t b_reg, b_next;
    word_t p_reg, p_next;
    cnt_t  cnt_reg, cnt_next;
    logic  busy_reg, busy_next;
    logic  done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            p_next    = '0;
            cnt_next  = CNT_TOP;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add one partial product per cycle, low word only
            if (b_reg[0])
            begin
                p_next = p_reg + a_reg;
            end
            a_next = {a_reg[WIDTH-2:0], 1'b0};
            b_next = {1'b0, b_reg[WIDTH-1:1]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = p_reg;

endmodule

// ===== hw/rtl/ipow_checker.sv =====
module ipow_checker
    import ipow_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic signed [WIDTH-1:0]  base,
    input logic signed [WIDTH-1:0]  exponent,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [WIDTH-1:0]  power
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power))
        else $error("output beat dropped or changed while stalled");

    a_in_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> $stable(base) && $stable(exponent))
        else $error("input beat changed while waiting");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while an item is in flight");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an item in flight");

    a_no_result_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared in the cycle after an accept");

endmodule

bind integer_power_by_squaring ipow_checker u_ipow_checker (.*);

// ===== bench/tb.sv =====
module tb;
    import ipow_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned TAIL_CYCLES = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [WIDTH-1:0] base = '0;
    logic signed [WIDTH-1:0] exponent = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [WIDTH-1:0] power;

    word_t power_expect [$];
    int unsigned cycle_count = 0;
    int unsigned beats_in = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned nonpos_count = 0;
    int unsigned wide_count = 0;
    bit tx_bursty = 1'b1;
    bit rx_bursty = 1'b1;
    int unsigned rx_hold_left = 0;
    int unsigned rx_stall_left = 0;

    integer_power_by_squaring dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .power     (power)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // square-and-multiply from the top exponent bit, every product wrapped to WIDTH bits
    function automatic word_t power_by_squaring(word_t b, word_t e);
        word_t acc;
        acc = WORD_ONE;
        if (e == '0 || e[WIDTH-1])
            return WORD_ONE;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            acc = acc * acc;
            if (e[i])
                acc = acc * b;
        end
        return acc;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            power_expect.push_back(power_by_squaring(word_t'(base), word_t'(exponent)));
            beats_in++;
            if (exponent <= 0)
                nonpos_count++;
        end
    end

    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (power_expect.size() == 0)
            begin
                $error("power: expected none, got %0d", power);
                mismatch_count++;
            end
            else
            begin
                want = power_expect.pop_front();
                results_checked++;
                if (word_t'(power) !== want)
                begin
                    $error("power: expected %0d, got %0d", $signed(want), power);
                    mismatch_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_stall_left > 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_bursty && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left = $urandom_range(0, 16);
        end
        else
            out_ready <= 1'b1;
    end

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(word_t b, word_t e);
        if (tx_bursty && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        base <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (power_expect.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic pick_operands(output word_t b, output word_t e);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            e = word_t'($urandom) | (WORD_ONE << (WIDTH - 1));
        else if (sel < 11)
            e = '0;
        else if (sel < 15)
        begin
            e = word_t'($urandom) & ~(WORD_ONE << (WIDTH - 1));
            wide_count++;
        end
        else if (sel < 20)
            e = WORD_ONE;
        else
            e = word_t'($urandom_range(2, 255));
        sel = $urandom_range(0, 99);
        if (sel < 50)
            b = word_t'($urandom);
        else if (sel < 80)
            b = word_t'(int'($urandom_range(0, 32)) - 16);
        else
        begin
            case ($urandom_range(0, 4))
                0: b = '0;
                1: b = WORD_ONE;
                2: b = '1;
                3: b = WORD_ONE << (WIDTH - 1);
                default: b = ~(WORD_ONE << (WIDTH - 1));
            endcase
        end
    endtask

    task automatic send_random(int unsigned count);
        word_t b;
        word_t e;
        repeat (count)
        begin
            pick_operands(b, e);
            send_beat(b, e);
        end
    endtask

    task automatic test_corner_operands();
        send_beat(32'h0000_0000, 32'h0000_0000);
        send_beat(32'h0000_0005, 32'h0000_0000);
        send_beat(32'h0000_0007, 32'hFFFF_FFFF);
        send_beat(32'h0000_0000, 32'h8000_0000);
        send_beat(32'h8000_0000, 32'h8000_0000);
        send_beat(32'h7FFF_FFFF, 32'h0000_0001);
        send_beat(32'h8000_0000, 32'h0000_0001);
        send_beat(32'hFFFF_FFFD, 32'h0000_0001);
        send_beat(32'h0000_0000, 32'h0000_0001);
        send_beat(32'h0000_0000, 32'h0000_0007);
        send_beat(32'h0000_0001, 32'h7FFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'h7FFF_FFFE);
        send_beat(32'h0000_0002, 32'h0000_001E);
        send_beat(32'h0000_0002, 32'h0000_001F);
        send_beat(32'h0000_0002, 32'h0000_0020);
        send_beat(32'h7FFF_FFFF, 32'h0000_0002);
        send_beat(32'h8000_0000, 32'h0000_0002);
        send_beat(32'h0000_0003, 32'h0000_0014);
        send_beat(32'hFFFF_FFF9, 32'h0000_000D);
        send_beat(32'h0000_000A, 32'h0000_0009);
        send_beat(32'hDEAD_BEEF, 32'h7FFF_FFFF);
    endtask

    task automatic test_output_backpressure();
        word_t b;
        word_t e;
        in_valid <= 1'b0;
        @(posedge clk);
        rx_hold_left = 900;
        @(negedge clk);
        repeat (6)
        begin
            b = word_t'($urandom);
            e = word_t'($urandom_range(0, 40));
            send_beat(b, e);
        end
    endtask

    task automatic test_pause_until_empty();
        send_random(4);
        wait_all_results();
        send_random(4);
    endtask

    task automatic test_streaming();
        in_valid <= 1'b0;
        @(posedge clk);
        tx_bursty = 1'b0;
        rx_bursty = 1'b0;
        @(negedge clk);
        send_random(800);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_corner_operands();
        send_random(610);
        test_output_backpressure();
        test_pause_until_empty();
        test_streaming();
        wait_all_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("tb: %0d beats in, %0d powers compared, %0d mismatches", beats_in,
                 results_checked, mismatch_count);
        $display("tb: %0d non-positive and %0d full-width exponents, with stalls on both sides",
                 nonpos_count, wide_count);
        if (mismatch_count == 0 && power_expect.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ipow_pkg.sv
hw/rtl/ipow_mul.sv
hw/rtl/integer_power_by_squaring.sv
hw/rtl/ipow_checker.sv
bench/tb.sv
